/* sv/fsl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FSK tone log-likelihood: shared types and constants
// Result type, saturation bounds and the stage layout of the iterative lanes.
// ----------------------------------------------------------------------------
package fsl_pkg;

  typedef logic signed [23:0] llr_t;

  localparam llr_t LLR_MAX = 24'sh7FFFFF;
  localparam llr_t LLR_MIN = 24'sh800000;

  // square root: 32 root bits, 4 per stage
  localparam int SQRT_STG   = 8;
  localparam int SQRT_STEPS = 4;

  // divider: 24 quotient bits, 4 per stage
  localparam int DIV_STG   = 6;
  localparam int DIV_STEPS = 4;

  // log I0 approximation stages
  localparam int LOGI0_STG = 6;

endpackage

/* sv/fsl_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FSK tone log-likelihood: pipelined integer square root
// floor(sqrt(rad)) of a 64-bit radicand, restoring digit recurrence.
// ----------------------------------------------------------------------------
module fsl_sqrt
  import fsl_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);

  logic [32:0] rem_q  [SQRT_STG];
  logic [31:0] root_q [SQRT_STG];
  logic [63:0] rad_q  [SQRT_STG];

  for (genvar g = 0; g < SQRT_STG; g++) begin : g_stg
    logic [32:0] rem_in, rem_d;
    logic [31:0] root_in, root_d;
    logic [63:0] rad_in, rad_d;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign rad_in  = rad_q[g-1];
    end

    always_comb begin
      logic [34:0] acc;
      logic [34:0] trial;
      logic [34:0] diff;
      rem_d  = rem_in;
      root_d = root_in;
      rad_d  = rad_in;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        acc   = {rem_d, rad_d[63:62]};
        trial = {1'b0, root_d, 2'b01};
        diff  = acc - trial;
        rad_d = {rad_d[61:0], 2'b00};
        if (acc >= trial) begin
          rem_d  = diff[32:0];
          root_d = {root_d[30:0], 1'b1};
        end else begin
          rem_d  = acc[32:0];
          root_d = {root_d[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        root_q[g] <= root_d;
        rad_q[g]  <= rad_d;
      end
    end
  end

  assign root_o = root_q[SQRT_STG-1];

endmodule

/* sv/fsl_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FSK tone log-likelihood: pipelined restoring divider
// 24 quotient bits of {rem, lo} / den, given rem < den.
// ----------------------------------------------------------------------------
module fsl_div
  import fsl_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [16:0] rem_i,
  input  logic [23:0] lo_i,
  input  logic [16:0] den_i,
  output logic [23:0] quo_o
);

  logic [16:0] rem_q [DIV_STG];
  logic [23:0] lo_q  [DIV_STG];
  logic [16:0] den_q [DIV_STG];

  for (genvar g = 0; g < DIV_STG; g++) begin : g_stg
    logic [16:0] rem_in, rem_d, den_in;
    logic [23:0] lo_in, lo_d;

    if (g == 0) begin : g_first
      assign rem_in = rem_i;
      assign lo_in  = lo_i;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign lo_in  = lo_q[g-1];
      assign den_in = den_q[g-1];
    end

    // quotient bits shift in at the bottom of lo as dividend bits leave the top
    always_comb begin
      logic [17:0] acc;
      logic [17:0] diff;
      rem_d = rem_in;
      lo_d  = lo_in;
      for (int k = 0; k < DIV_STEPS; k++) begin
        acc  = {rem_d, lo_d[23]};
        diff = acc - {1'b0, den_in};
        lo_d = {lo_d[22:0], 1'b0};
        if (acc >= {1'b0, den_in}) begin
          rem_d   = diff[16:0];
          lo_d[0] = 1'b1;
        end else begin
          rem_d = acc[16:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= rem_d;
        lo_q[g]  <= lo_d;
        den_q[g] <= den_in;
      end
    end
  end

  assign quo_o = lo_q[DIV_STG-1];

endmodule

/* sv/fsl_logi0.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FSK tone log-likelihood: log I0 approximation
// Five-segment piecewise quadratic in x (Q.16), rounded and saturated to Q11.12.
// ----------------------------------------------------------------------------
module fsl_logi0
  import fsl_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [32:0] x_i,
  output llr_t        llr_o
);

  localparam logic [27:0] SEG_LIM [4] = '{28'd65536, 28'd131072, 28'd327680, 28'd1310720};
  localparam logic [11:0] COEF_A  [5] = '{12'd2260, 12'd1245, 12'd288, 12'd20, 12'd0};
  localparam logic [13:0] COEF_B  [5] = '{14'd125, 14'd2177, 14'd6314, 14'd9048, 14'd9867};
  localparam logic signed [15:0] COEF_C [5] =
    '{-16'sd12, -16'sd1080, -16'sd5645, -16'sd12997, -16'sd22053};

  // rounding half of 10000 * 2^20, and a bias that keeps the dividend positive
  localparam logic signed [63:0] ROUND_OFS = 64'sd5000 <<< 20;
  localparam logic signed [63:0] W_SAT     = 64'sd83886080000;
  localparam logic signed [63:0] BIAS_W    = 64'sd160000;
  localparam logic [24:0]        BIAS_Q    = 25'd16;
  localparam logic [24:0]        RECIP_625 = 25'd27487790;
  localparam logic [33:0]        DIV_625   = 34'd625;

  // stage 1: segment select
  logic        sat1_d;
  logic [2:0]  seg1_d;
  logic        sat1_q;
  logic [27:0] x1_q;
  logic [11:0] a1_q;
  logic [13:0] b1_q;
  logic signed [15:0] c1_q;

  always_comb begin
    sat1_d = |x_i[32:28];
    seg1_d = '0;
    for (int k = 0; k < 4; k++) begin
      seg1_d = seg1_d + {2'b00, (x_i[27:0] >= SEG_LIM[k])};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat1_q <= sat1_d;
      x1_q   <= x_i[27:0];
      a1_q   <= COEF_A[seg1_d];
      b1_q   <= COEF_B[seg1_d];
      c1_q   <= COEF_C[seg1_d];
    end
  end

  // stage 2: square and linear term
  logic        sat2_q;
  logic [41:0] sq2_q;
  logic [41:0] tb2_q;
  logic [11:0] a2_q;
  logic signed [15:0] c2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat2_q <= sat1_q;
      sq2_q  <= x1_q[20:0] * x1_q[20:0];
      tb2_q  <= b1_q * x1_q;
      a2_q   <= a1_q;
      c2_q   <= c1_q;
    end
  end

  // stage 3: quadratic term
  logic        sat3_q;
  logic [53:0] ta3_q;
  logic [41:0] tb3_q;
  logic signed [15:0] c3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat3_q <= sat2_q;
      ta3_q  <= a2_q * sq2_q;
      tb3_q  <= tb2_q;
      c3_q   <= c2_q;
    end
  end

  // stage 4: sum, drop 2^20, bias, divide by 16
  logic signed [63:0] v4, w4, u4;
  logic        sat4_d;
  logic        sat4_q;
  logic [32:0] u4_q;

  always_comb begin
    v4 = $signed({10'b0, ta3_q}) + $signed({6'b0, tb3_q, 16'b0})
       + ($signed(64'(c3_q)) <<< 32) + ROUND_OFS;
    w4 = v4 >>> 20;
    u4 = w4 + BIAS_W;
    sat4_d = sat3_q | (w4 >= W_SAT);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat4_q <= sat4_d;
      u4_q   <= u4[36:4];
    end
  end

  // stage 5: reciprocal multiply by 1/625, may fall one short
  logic [57:0] prod5;
  logic        sat5_q;
  logic [32:0] u5_q;
  logic [23:0] q5_q;

  assign prod5 = u4_q * RECIP_625;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat5_q <= sat4_q;
      u5_q   <= u4_q;
      q5_q   <= prod5[57:34];
    end
  end

  // stage 6: correct, remove bias, saturate
  logic [33:0] r6;
  logic [24:0] q6, qb6;
  llr_t        llr6_q;

  always_comb begin
    r6  = {1'b0, u5_q} - ({10'b0, q5_q} * DIV_625);
    q6  = {1'b0, q5_q} + {24'b0, (r6 >= DIV_625)};
    qb6 = q6 - BIAS_Q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      llr6_q <= sat5_q ? LLR_MAX : $signed(qb6[23:0]);
    end
  end

  assign llr_o = llr6_q;

endmodule

/* sv/fsk_symbol_loglikelihood.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FSK tone log-likelihood
// Per-tone soft demodulator: coherent, noncoherent with amplitude (log I0)
// and noncoherent without amplitude modes, Q3.12 in, saturated Q11.12 out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one tone per transaction:
//   matched-filter output, the symbol's fading coefficient and a last-tone
//   flag. Output channel (out_valid_o / out_stall_i) returns one llr per tone
//   in the same order, with symbol_end_o copying the flag.
//   The pipeline takes one transaction per cycle in sustained operation
//   while the output does not stall. Its depth is set by the 32-bit
//   square root (8 stages of 4 digits) in front of the log I0 evaluation.
//   Registers: index 0 esno (Q8.8, reset 256), index 1 csi_mode (reset 0);
//   write them only while no transaction is in flight.
//   Reset clears all valid bits and loads the register defaults.
//   A stall while out_valid_o is high holds the whole pipeline and asserts
//   in_stall_o in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module fsk_symbol_loglikelihood
  import fsl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] rx_real_i,
  input  logic signed [15:0] rx_imag_i,
  input  logic signed [15:0] fade_real_i,
  input  logic signed [15:0] fade_imag_i,
  input  logic               tone_last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] llr_o,
  output logic               symbol_end_o
);

  typedef enum logic [1:0] {
    MODE_COH    = 2'd0,
    MODE_NC_AMP = 2'd1,
    MODE_NC_POW = 2'd2,
    MODE_OFF    = 2'd3
  } csi_mode_e;

  localparam logic      CFG_ESNO = 1'b0;
  localparam logic      CFG_MODE = 1'b1;
  localparam logic [15:0] ESNO_RST = 16'd256;

  localparam int S_SQRT_OUT = 4 + SQRT_STG;
  localparam int S_XMUL     = S_SQRT_OUT + 1;
  localparam int S_LOG_OUT  = S_XMUL + LOGI0_STG;
  localparam int S_DIV_OUT  = 6 + DIV_STG;
  localparam int NSTG       = S_LOG_OUT + 1;
  localparam int LLR0_LEN   = S_LOG_OUT - 4;
  localparam int SAT2_LEN   = DIV_STG + 1;
  localparam int LLR2_LEN   = S_LOG_OUT - S_DIV_OUT;

  // configuration
  logic [15:0] esno_q;
  csi_mode_e   mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esno_q <= ESNO_RST;
      mode_q <= MODE_COH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ESNO: esno_q <= cfg_data_i;
        CFG_MODE: mode_q <= csi_mode_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // pipeline control: every stage advances unless the output is held
  logic en;
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] last_q;
  csi_mode_e       cmode_q [NSTG];

  assign in_stall_o = out_valid_o & out_stall_i;
  assign en         = ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      last_q     <= {last_q[NSTG-2:0], tone_last_i};
      cmode_q[0] <= mode_q;
      for (int k = 1; k < NSTG; k++) begin
        cmode_q[k] <= cmode_q[k-1];
      end
    end
  end

  // stages 1-4: products, sums, wide products
  logic signed [15:0] yr1_q, yi1_q, ar1_q, ai1_q;
  logic signed [31:0] prr2_q, pii2_q;
  logic [30:0]        syr2_q, syi2_q, sar2_q, sai2_q;
  logic signed [31:0] syr_w, syi_w, sar_w, sai_w;
  logic signed [32:0] dot3_q;
  logic [31:0]        yp3_q, ap3_q;
  logic signed [49:0] m0_4_q;
  logic [63:0]        n4_q;
  logic [47:0]        t4_q;

  assign syr_w = yr1_q * yr1_q;
  assign syi_w = yi1_q * yi1_q;
  assign sar_w = ar1_q * ar1_q;
  assign sai_w = ai1_q * ai1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      yr1_q  <= rx_real_i;
      yi1_q  <= rx_imag_i;
      ar1_q  <= fade_real_i;
      ai1_q  <= fade_imag_i;
      prr2_q <= yr1_q * ar1_q;
      pii2_q <= yi1_q * ai1_q;
      syr2_q <= syr_w[30:0];
      syi2_q <= syi_w[30:0];
      sar2_q <= sar_w[30:0];
      sai2_q <= sai_w[30:0];
      dot3_q <= 33'(prr2_q) + 33'(pii2_q);
      yp3_q  <= {1'b0, syr2_q} + {1'b0, syi2_q};
      ap3_q  <= {1'b0, sar2_q} + {1'b0, sai2_q};
      m0_4_q <= dot3_q * $signed({1'b0, esno_q});
      n4_q   <= ap3_q * yp3_q;
      t4_q   <= yp3_q * esno_q;
    end
  end

  // coherent lane: round by 2^19 and saturate, then delay
  logic signed [49:0] r0;
  llr_t               llr0_d;
  llr_t               llr0_q [LLR0_LEN];

  always_comb begin
    r0 = (m0_4_q + (50'sd1 <<< 18)) >>> 19;
    if (r0 > LLR_MAX) begin
      llr0_d = LLR_MAX;
    end else if (r0 < LLR_MIN) begin
      llr0_d = LLR_MIN;
    end else begin
      llr0_d = r0[23:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      llr0_q[0] <= llr0_d;
      for (int k = 1; k < LLR0_LEN; k++) begin
        llr0_q[k] <= llr0_q[k-1];
      end
    end
  end

  // power lane: P*E^2 + half divisor, drop 2^20, divide by 256+E
  logic [63:0] num5_q;
  logic [16:0] den6;
  logic [63:0] nsum6;
  logic [16:0] den6_q, hi6_q;
  logic [23:0] lo6_q;
  logic        sat2_q [SAT2_LEN];
  logic [23:0] quo;
  llr_t        llr2_q [LLR2_LEN];

  assign den6  = {1'b0, esno_q} + 17'd256;
  assign nsum6 = num5_q + {28'b0, den6, 19'b0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      num5_q    <= t4_q * esno_q;
      den6_q    <= den6;
      hi6_q     <= nsum6[60:44];
      lo6_q     <= nsum6[43:20];
      sat2_q[0] <= nsum6[63:44] >= {3'b0, den6};
      for (int k = 1; k < SAT2_LEN; k++) begin
        sat2_q[k] <= sat2_q[k-1];
      end
      llr2_q[0] <= (sat2_q[SAT2_LEN-1] | quo[23]) ? LLR_MAX : $signed({1'b0, quo[22:0]});
      for (int k = 1; k < LLR2_LEN; k++) begin
        llr2_q[k] <= llr2_q[k-1];
      end
    end
  end

  fsl_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (hi6_q),
    .lo_i  (lo6_q),
    .den_i (den6_q),
    .quo_o (quo)
  );

  // amplitude lane: sqrt(|a|^2 |y|^2), scale by 2*EsNo, log I0
  logic [31:0] root;
  logic [47:0] xprod;
  logic [32:0] x13_q;
  llr_t        llr1;

  fsl_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (n4_q),
    .root_o (root)
  );

  assign xprod = root * esno_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x13_q <= xprod[47:15];
    end
  end

  fsl_logi0 u_logi0 (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (x13_q),
    .llr_o (llr1)
  );

  // output register: pick the lane of this transaction's mode
  llr_t llr_d;
  llr_t llr_q;

  always_comb begin
    case (cmode_q[NSTG-2])
      MODE_COH:    llr_d = llr0_q[LLR0_LEN-1];
      MODE_NC_AMP: llr_d = llr1;
      MODE_NC_POW: llr_d = llr2_q[LLR2_LEN-1];
      default:     llr_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      llr_q <= llr_d;
    end
  end

  assign llr_o        = llr_q;
  assign out_valid_o  = vld_q[NSTG-1];
  assign symbol_end_o = last_q[NSTG-1];

`ifndef SYNTHESIS
  a_pow_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cmode_q[NSTG-1] == MODE_NC_POW) |-> !llr_o[23])
    else $error("negative llr in power mode");

  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cmode_q[NSTG-1] == MODE_OFF) |-> (llr_o == '0))
    else $error("nonzero llr in unused mode");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q))
    else $error("pipeline moved while held");
`endif

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FSK tone log-likelihood testbench
// Drives directed and random tones through all CSI modes and SNR settings
// with random idling on both channels, and checks every llr and symbol_end
// against an in-bench predictor, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import fsl_pkg::*;

  typedef enum logic [1:0] {
    MODE_COHERENT = 2'd0,
    MODE_NC_AMP   = 2'd1,
    MODE_NC_POWER = 2'd2,
    MODE_UNUSED   = 2'd3
  } csi_mode_e;

  localparam logic REG_ESNO = 1'b0;
  localparam logic REG_MODE = 1'b1;
  localparam int   DRAIN_CYCLES = 30;

  typedef struct {
    llr_t llr;
    logic symbol_end;
  } tone_result_t;

  typedef struct {
    logic [15:0]       esno;
    csi_mode_e         mode;
    logic signed [15:0] yr, yi, ar, ai;
    logic              last;
    logic              known;
    llr_t              llr;
  } tone_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = 1'b0;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] rx_real_i = '0;
  logic signed [15:0] rx_imag_i = '0;
  logic signed [15:0] fade_real_i = '0;
  logic signed [15:0] fade_imag_i = '0;
  logic               tone_last_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b1;
  logic signed [23:0] llr_o;
  logic               symbol_end_o;

  logic [15:0]  cur_esno = 16'd256;
  csi_mode_e    cur_mode = MODE_COHERENT;
  tone_result_t llr_pending[$];
  llr_t         known_llr[$];
  logic         known_flag[$];
  int           mismatches = 0;
  int           tones_sent = 0;
  int           tones_checked = 0;
  bit           idle_on = 1'b0;
  bit           long_hold_req = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  fsk_symbol_loglikelihood u_dut (.*);

  function automatic longint floor_div(longint v, longint d);
    if (v >= 0) return v / d;
    return -(((-v) + d - 1) / d);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic llr_t predict_llr(logic signed [15:0] yr, yi, ar, ai,
                                       logic [15:0] e, csi_mode_e mode);
    longint v, x, c2, c1, c0;
    longint unsigned ap, yp, m, num, den, q;
    v = 0;
    case (mode)
      MODE_COHERENT: begin
        v = (longint'(yr) * ar + longint'(yi) * ai) * 2 * longint'(e);
        v = (v + (64'sd1 <<< 19)) >>> 20;
      end
      MODE_NC_AMP: begin
        ap = longint'(ar) * ar + longint'(ai) * ai;
        yp = longint'(yr) * yr + longint'(yi) * yi;
        m = int_sqrt(ap * yp);
        x = longint'((m * e) >> 15);
        if (x < 65536) begin
          c2 = 2260; c1 = 125;  c0 = -12;
        end else if (x < 131072) begin
          c2 = 1245; c1 = 2177; c0 = -1080;
        end else if (x < 327680) begin
          c2 = 288;  c1 = 6314; c0 = -5645;
        end else if (x < 1310720) begin
          c2 = 20;   c1 = 9048; c0 = -12997;
        end else begin
          c2 = 0;    c1 = 9867; c0 = -22053;
        end
        // top segment has no square term; skip it so x*x cannot wrap
        v = ((c2 == 0) ? 64'sd0 : c2 * x * x) + c1 * x * 65536 + c0 * (64'sd1 <<< 32);
        v = floor_div(v + ((64'sd10000 <<< 20) / 2), 64'sd10000 <<< 20);
      end
      MODE_NC_POWER: begin
        yp = longint'(yr) * yr + longint'(yi) * yi;
        den = (64'd256 + e) << 20;
        num = yp * e * e;
        q = (num + den / 2) / den;
        v = (q > 64'd8388607) ? 64'sd8388607 : longint'(q);
      end
      default: v = 0;
    endcase
    if (v > LLR_MAX) v = LLR_MAX;
    if (v < LLR_MIN) v = LLR_MIN;
    return llr_t'(v);
  endfunction

  // input monitor: queue the expectation for each accepted transaction
  always @(posedge clk_i) begin
    tone_result_t r;
    if (in_valid_i && !in_stall_o) begin
      r.llr = predict_llr(rx_real_i, rx_imag_i, fade_real_i, fade_imag_i,
                          cur_esno, cur_mode);
      r.symbol_end = tone_last_i;
      llr_pending.push_back(r);
      tones_sent++;
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    tone_result_t r;
    llr_t k;
    logic kf;
    if (out_valid_o && !out_stall_i) begin
      if (llr_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: llr %0d", llr_o);
      end else begin
        r = llr_pending.pop_front();
        k = known_llr.pop_front();
        kf = known_flag.pop_front();
        if (kf && k !== r.llr) begin
          mismatches++;
          if (mismatches <= 10) $display("table llr %0d disagrees with prediction %0d", k, r.llr);
        end
        if (llr_o !== r.llr || symbol_end_o !== r.symbol_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at tone %0d: exp llr %0d end %0b, got llr %0d end %0b",
                     tones_checked, r.llr, r.symbol_end, llr_o, symbol_end_o);
        end
        tones_checked++;
      end
    end
  end

  // receiver: random stall before each result, or a long hold on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = idle_on ? $urandom_range(0, 5) : 0;
      if (long_hold_req) begin
        n = 300;
        long_hold_req = 1'b0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  task automatic drain();
    while (llr_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == REG_ESNO) cur_esno = data;
    else cur_mode = csi_mode_e'(data[1:0]);
  endtask

  task automatic set_config(logic [15:0] e, csi_mode_e mode);
    drain();
    @(posedge clk_i);
    if (e != cur_esno) write_reg(REG_ESNO, e);
    if (mode != cur_mode) write_reg(REG_MODE, 16'(mode));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_tone(logic signed [15:0] yr, yi, ar, ai, logic last,
                           logic known, llr_t k);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    rx_real_i   <= yr;
    rx_imag_i   <= yi;
    fade_real_i <= ar;
    fade_imag_i <= ai;
    tone_last_i <= last;
    known_llr.push_back(k);
    known_flag.push_back(known);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic signed [15:0] rand_sample();
    logic signed [15:0] s;
    s = 16'($urandom);
    // mostly scale down so every log I0 segment gets hit
    if ($urandom_range(0, 3) != 0) s = s >>> $urandom_range(0, 12);
    return s;
  endfunction

  task automatic random_phase(int count, logic [15:0] e, csi_mode_e mode);
    set_config(e, mode);
    repeat (count) begin
      send_tone(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                1'($urandom), 1'b0, '0);
      if ($urandom_range(0, 31) == 0) idle_on = !idle_on;
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  tone_row_t dir_rows[] = '{
    '{16'd256,   MODE_COHERENT, 16'sd4096,  16'sd0,      16'sd4096,  16'sd0,      1'b1, 1'b1, 24'sd8192},
    '{16'd256,   MODE_COHERENT, 16'sd1234,  -16'sd2000,  -16'sd300,  16'sd77,     1'b0, 1'b0, 24'sd0},
    '{16'd65535, MODE_COHERENT, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1, 1'b1, LLR_MAX},
    '{16'd65535, MODE_COHERENT, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 1'b0, 1'b1, LLR_MIN},
    '{16'd0,     MODE_COHERENT, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 1'b1, 1'b1, 24'sd0},
    '{16'd0,     MODE_NC_AMP,   16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 1'b1, -24'sd5},
    '{16'd512,   MODE_NC_AMP,   16'sd0,     16'sd0,     16'sd4096,  16'sd0,      1'b1, 1'b1, -24'sd5},
    '{16'd512,   MODE_NC_AMP,   16'sd2048,  16'sd0,     16'sd4096,  16'sd0,      1'b0, 1'b0, 24'sd0},
    '{16'd512,   MODE_NC_AMP,   16'sd4096,  16'sd0,     16'sd4096,  16'sd0,      1'b1, 1'b0, 24'sd0},
    '{16'd512,   MODE_NC_AMP,   16'sd8192,  16'sd2000,  16'sd4096,  -16'sd100,   1'b0, 1'b0, 24'sd0},
    '{16'd512,   MODE_NC_AMP,   16'sd20000, 16'sd0,     16'sd4096,  16'sd0,      1'b1, 1'b0, 24'sd0},
    '{16'd65535, MODE_NC_AMP,   -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 1'b1, LLR_MAX},
    '{16'd65535, MODE_NC_POWER, -16'sd32768, -16'sd32768, 16'sd0,     16'sd0,      1'b1, 1'b1, LLR_MAX},
    '{16'd256,   MODE_NC_POWER, 16'sd4096,  -16'sd4096, 16'sd5,     16'sd9,      1'b0, 1'b0, 24'sd0},
    '{16'd0,     MODE_NC_POWER, 16'sd32767, 16'sd32767, 16'sd1,     16'sd1,      1'b1, 1'b1, 24'sd0},
    '{16'd300,   MODE_UNUSED,   16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767, 1'b1, 1'b1, 24'sd0},
    '{16'd300,   MODE_UNUSED,   16'sd100,   16'sd200,   16'sd300,   16'sd400,    1'b0, 1'b1, 24'sd0}
  };

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].esno != cur_esno || dir_rows[i].mode != cur_mode) begin
        in_valid_i <= 1'b0;
        set_config(dir_rows[i].esno, dir_rows[i].mode);
      end
      send_tone(dir_rows[i].yr, dir_rows[i].yi, dir_rows[i].ar, dir_rows[i].ai,
                dir_rows[i].last, dir_rows[i].known, dir_rows[i].llr);
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    idle_on = 1'b1;
    random_phase(200, 16'd256, MODE_COHERENT);
    random_phase(150, 16'd65535, MODE_COHERENT);
    random_phase(250, 16'd700, MODE_NC_AMP);
    random_phase(100, 16'd65535, MODE_NC_AMP);
    random_phase(100, 16'd1, MODE_NC_AMP);

    // hold off the receiver while the sender keeps pushing back to back
    idle_on = 1'b0;
    set_config(16'($urandom_range(1, 4000)), MODE_NC_AMP);
    long_hold_req = 1'b1;
    repeat (120)
      send_tone(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                1'($urandom), 1'b0, '0);
    in_valid_i <= 1'b0;

    idle_on = 1'b1;
    random_phase(200, 16'd300, MODE_NC_POWER);
    random_phase(100, 16'd65535, MODE_NC_POWER);
    random_phase(60, 16'd0, MODE_NC_POWER);
    random_phase(60, 16'd0, MODE_COHERENT);
    random_phase(60, 16'd0, MODE_NC_AMP);
    random_phase(60, 16'd999, MODE_UNUSED);
    random_phase(150, 16'($urandom), MODE_COHERENT);
    // sender waits for everything in flight between the two phases
    drain();
    random_phase(150, 16'($urandom), MODE_NC_AMP);

    drain();
    if (llr_pending.size() != 0) mismatches++;
    $display("Covered %0d tones, %0d results checked, all CSI modes incl. unused,",
             tones_sent, tones_checked);
    $display("esno from 0 to 65535, saturation both ways and a long output hold.");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", llr_pending.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
sv/fsl_pkg.sv
sv/fsl_sqrt.sv
sv/fsl_div.sv
sv/fsl_logi0.sv
sv/fsk_symbol_loglikelihood.sv
bench/tb_top.sv
